FILE: src/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
package fpa_pkg;

  localparam int FRACT_BITS = 8;
  localparam int DW = 32 + FRACT_BITS;  // dividend / quotient width
  localparam int NCELL = DW;            // one quotient bit per cell

  typedef enum logic [3:0] {
    FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
    FN_GT = 4'd4, FN_LT = 4'd5, FN_GE = 4'd6, FN_LE = 4'd7,
    FN_EQ = 4'd8, FN_NE = 4'd9, FN_INC = 4'd10, FN_DEC = 4'd11,
    FN_MIN = 4'd12, FN_MAX = 4'd13, FN_FROM_INT = 4'd14, FN_TO_INT = 4'd15
  } func_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OVF  = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               valid;
    func_t              func;
    logic signed [31:0] result;   // final value of the simple operations
    logic               cond;
    logic [1:0]         status;
    logic signed [63:0] prod;
    logic               neg;      // quotient sign
    logic [31:0]        den;
    logic [DW-1:0]      num;
    logic [31:0]        rem;
    logic [DW-1:0]      quo;
  } item_t;

endpackage

FILE: src/fpa_pre.sv
// Input stage: decodes the operation, does the simple operations and the multiply, sets up the divide.
module fpa_pre (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [3:0]         func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_pkg::item_t     item
);
  import fpa_pkg::*;

  item_t item_next;
  logic [31:0] amag, bmag;
  logic fi_ovf;
  logic lt, eq;

  always_comb begin
    amag = operand_a[31] ? 32'(-operand_a) : operand_a;
    bmag = operand_b[31] ? 32'(-operand_b) : operand_b;
    lt = operand_a < operand_b;
    eq = operand_a == operand_b;
    // from_int overflows unless the top FRACT_BITS+1 bits agree
    fi_ovf = !((&operand_a[31:31-FRACT_BITS]) || !(|operand_a[31:31-FRACT_BITS]));

    item_next = '0;
    item_next.valid = start;
    item_next.func = func_t'(func);
    item_next.status = STAT_OK;
    item_next.prod = operand_a * operand_b;
    item_next.neg = operand_a[31] ^ operand_b[31];
    item_next.den = bmag;
    item_next.num = {amag, {FRACT_BITS{1'b0}}};
    case (func_t'(func))
      FN_ADD: item_next.result = operand_a + operand_b;
      FN_SUB: item_next.result = operand_a - operand_b;
      FN_GT:  item_next.cond = !lt && !eq;
      FN_LT:  item_next.cond = lt;
      FN_GE:  item_next.cond = !lt;
      FN_LE:  item_next.cond = lt || eq;
      FN_EQ:  item_next.cond = eq;
      FN_NE:  item_next.cond = !eq;
      FN_INC: item_next.result = operand_a + 32'sd1;
      FN_DEC: item_next.result = operand_a - 32'sd1;
      FN_MIN: item_next.result = lt ? operand_a : operand_b;
      FN_MAX: item_next.result = (!lt && !eq) ? operand_a : operand_b;
      FN_FROM_INT: begin
        if (fi_ovf) begin
          item_next.result = operand_a[31] ? S32_MIN : S32_MAX;
          item_next.status = STAT_OVF;
        end else begin
          item_next.result = operand_a <<< FRACT_BITS;
        end
      end
      FN_TO_INT: item_next.result = operand_a >>> FRACT_BITS;
      default: item_next.result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else begin
      item <= item_next;
    end
  end
endmodule

FILE: src/fpa_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the transaction on.
module fpa_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  fpa_pkg::item_t item_in,
  output fpa_pkg::item_t item_out
);
  import fpa_pkg::*;

  item_t item_next;
  logic [32:0] rshift;
  logic ge;

  always_comb begin
    rshift = {item_in.rem, item_in.num[DW-1]};
    ge = rshift >= {1'b0, item_in.den};
    item_next = item_in;
    item_next.rem = ge ? 32'(rshift - {1'b0, item_in.den}) : rshift[31:0];
    item_next.quo = {item_in.quo[DW-2:0], ge};
    item_next.num = {item_in.num[DW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out <= '0;
    end else begin
      item_out <= item_next;
    end
  end
endmodule

FILE: src/fpa_post.sv
// Output stage: multiply truncation, divide sign and saturation, result register.
module fpa_post (
  input  logic               clk,
  input  logic               rst,
  input  fpa_pkg::item_t     item,
  output logic               done,
  output logic signed [31:0] result,
  output logic               condition,
  output logic [1:0]         status
);
  import fpa_pkg::*;

  localparam logic [DW-1:0] QNEG_LIM = DW'(33'h0_8000_0000);
  localparam logic [DW-1:0] QPOS_LIM = DW'(33'h0_7fff_ffff);

  logic signed [63:0] padj, pq;
  logic signed [31:0] res_next;
  logic [1:0] st_next;

  always_comb begin
    // truncate toward zero: bias negative products before the shift
    padj = item.prod[63] ? item.prod + 64'sd2 ** FRACT_BITS - 64'sd1 : item.prod;
    pq = padj >>> FRACT_BITS;
    res_next = item.result;
    st_next = item.status;
    case (item.func)
      FN_MUL: begin
        if (pq > 64'(S32_MAX)) begin
          res_next = S32_MAX;
          st_next = STAT_OVF;
        end else if (pq < 64'(S32_MIN)) begin
          res_next = S32_MIN;
          st_next = STAT_OVF;
        end else begin
          res_next = pq[31:0];
        end
      end
      FN_DIV: begin
        if (item.den == '0) begin
          res_next = '0;
          st_next = STAT_DIVZ;
        end else if (item.neg) begin
          if (item.quo > QNEG_LIM) begin
            res_next = S32_MIN;
            st_next = STAT_OVF;
          end else begin
            res_next = 32'(-item.quo[31:0]);
          end
        end else if (item.quo > QPOS_LIM) begin
          res_next = S32_MAX;
          st_next = STAT_OVF;
        end else begin
          res_next = item.quo[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item.valid;
    end
    result <= res_next;
    condition <= item.cond;
    status <= st_next;
  end
endmodule

FILE: src/fixed_point_alu_q24_8_core.sv
// Top level of the Q24.8 fixed-point ALU: input stage, divider cell chain, output stage.
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   busy is always low: a new operation may enter every cycle.
//   func selects one of sixteen operations on operand_a and operand_b.
//   Every transaction gives one result: result, condition and status are
//   valid for the single cycle in which done is high.
// Pipeline: one input stage, a chain of 32 + FRACT_BITS division cells and
//   one output stage. All operations travel the same chain so results
//   leave in order.
// Throughput: one transaction per cycle; the divider cells each resolve
//   one quotient bit and hand the transaction to the next cell.
// Reset: synchronous rst clears every stage's valid bit; transactions in
//   flight are dropped and done stays low until new ones reach the end.
// The receiver cannot stall; results are not held back.
module fixed_point_alu_q24_8_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result,
  output logic               condition,
  output logic [1:0]         status
);
  import fpa_pkg::*;

  item_t chain [NCELL+1];

  assign busy = 1'b0;

  fpa_pre u_pre (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .operand_a(operand_a), .operand_b(operand_b), .item(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk(clk), .rst(rst), .item_in(chain[i]), .item_out(chain[i+1])
    );
  end

  fpa_post u_post (
    .clk(clk), .rst(rst), .item(chain[NCELL]), .done(done),
    .result(result), .condition(condition), .status(status)
  );

  a_stat_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_OVF || status == STAT_DIVZ))
    else $error("illegal status code");
  a_cond_zero: assert property (@(posedge clk) disable iff (rst)
    (done && condition) |-> (result == '0 && status == STAT_OK))
    else $error("comparison with nonzero result");
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_DIVZ) |-> result == '0)
    else $error("division by zero with nonzero result");
  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(start) |=> !busy)
    else $error("busy raised");
endmodule
